@@ hw/rtl/bbft_pkg.sv @@
// ----------------------------------------------------------------------------
// bbft_pkg: shared types and constants for the brace block fold table
// Field widths, operation and status codes, character codes, table entry
// layout and the result word carried to the output register.
// ----------------------------------------------------------------------------
package bbft_pkg;

  localparam int LINE_W   = 10;
  localparam int CHAR_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int NEXT_W   = LINE_W + 1;

  localparam int MAX_LINES_DEF   = 1024;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_VIEW   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_BLOCK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // One line's entry in the block table
  typedef struct packed {
    logic              valid;
    logic              fold;
    logic [LINE_W-1:0] end_ln;
  } tbl_entry_t;

  // One result word
  typedef struct packed {
    status_t           status;
    logic              pair_found;
    logic [LINE_W-1:0] pair_start;
    logic [LINE_W-1:0] pair_end;
    logic              is_block_start;
    logic              folded;
    logic [NEXT_W-1:0] next_line;
  } res_t;

endpackage

@@ hw/rtl/bbft_table.sv @@
// ----------------------------------------------------------------------------
// bbft_table: block end / fold table memory
// Memory with separate read and write ports and a registered read. After reset
// a sweep clears every entry, one per cycle, and busy stays high until done.
// ----------------------------------------------------------------------------
module bbft_table
  import bbft_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LINES)-1:0] rd_addr,
  output tbl_entry_t                   rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_LINES)-1:0] wr_addr,
  input  tbl_entry_t                   wr_data,
  output logic                         busy
);

  localparam int SLOT_W = $clog2(MAX_LINES);

  tbl_entry_t              mem [MAX_LINES];
  tbl_entry_t              rd_data_r;
  logic                    clr_active_r;
  logic [SLOT_W-1:0]       clr_idx_r;

  // Sweep the table clear after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == SLOT_W'(MAX_LINES - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + SLOT_W'(1);
    end
  end

  // Write port: clear sweep wins
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

@@ hw/rtl/brace_block_fold_table.sv @@
// ----------------------------------------------------------------------------
// brace_block_fold_table: brace matching stack with block fold table
// Scans source characters, pairs braces into blocks and keeps a fold flag
// per block start line for display queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_operation, in_char_code, in_line) and result words
//   (out_*) both use valid/ready. Every accepted word yields exactly one
//   result word, in order.
//   Each word is accepted in idle, where the stack and the block table are
//   read; in execute it writes back and loads the output register once
//   that register is free or being read. A new word is not accepted until
//   the last one has left execute.
//   A new word is accepted while a finished result waits in the output
//   register; a stalled receiver holds the following word in execute until
//   the output register drains.
//   After reset the block table is swept clear, with in_ready low until
//   the sweep is done; the stack count resets to zero.
//   Lines index the table modulo MAX_LINES; reported lines keep their value.
// ----------------------------------------------------------------------------
module brace_block_fold_table
  import bbft_pkg::*;
#(
  parameter int MAX_LINES   = MAX_LINES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [LINE_W-1:0] in_line,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic              out_pair_found,
  output logic [LINE_W-1:0] out_pair_start,
  output logic [LINE_W-1:0] out_pair_end,
  output logic              out_is_block_start,
  output logic              out_folded,
  output logic [NEXT_W-1:0] out_next_line
);

  localparam int SLOT_W = $clog2(MAX_LINES);
  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // Reduce a line to its table slot by restoring subtraction
  function automatic logic [SLOT_W-1:0] slot_of(input logic [LINE_W-1:0] ln);
    logic [LINE_W-1:0] r;
    r = ln;
    for (int k = LINE_W - 1; k >= 0; k--) begin
      if ((MAX_LINES << k) < (1 << LINE_W)) begin
        if (r >= LINE_W'(MAX_LINES << k)) begin
          r = r - LINE_W'(MAX_LINES << k);
        end
      end
    end
    return SLOT_W'(r);
  endfunction

  fsm_t              state_r, state_nxt;
  logic              accept;
  logic              exec_go;
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [LINE_W-1:0] line_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cnt_dec;
  logic [LINE_W-1:0] stk_mem [STACK_DEPTH];
  logic [LINE_W-1:0] stk_rd_r;
  logic              push_en;
  logic              pop_en;
  tbl_entry_t        tbl_rd;
  logic              tbl_wr_en;
  logic [SLOT_W-1:0] tbl_wr_addr;
  tbl_entry_t        tbl_wr_data;
  logic              tbl_busy;
  logic              rep_fold;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r, out_valid_nxt;

  assign accept  = in_valid && in_ready;
  assign cnt_dec = count_r - CNT_W'(1);

  bbft_table #(
    .MAX_LINES (MAX_LINES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (slot_of(in_line)),
    .rd_data (tbl_rd),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .busy    (tbl_busy)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    exec_go   = 1'b0;
    unique case (state_r)
      FSM_CLEAR: begin
        if (!tbl_busy) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid_r || out_ready) begin
          exec_go   = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      ch_r   <= in_char_code;
      line_r <= in_line;
    end
  end

  // Execute: decide the result and the write-backs
  always_comb begin
    res         = '0;
    push_en     = 1'b0;
    pop_en      = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = slot_of(line_r);
    tbl_wr_data = tbl_rd;
    rep_fold    = (op_r == OP_TOGGLE) ? !tbl_rd.fold : tbl_rd.fold;
    case (op_r) inside
      OP_SCAN: begin
        if (ch_r == CH_OPEN) begin
          if (count_r == CNT_W'(STACK_DEPTH)) begin
            res.status = ST_OVERFLOW;
          end else begin
            push_en = 1'b1;
          end
        end else if (ch_r == CH_CLOSE) begin
          if (count_r == '0) begin
            res.status = ST_UNMATCHED;
          end else begin
            pop_en                 = 1'b1;
            tbl_wr_en              = 1'b1;
            tbl_wr_addr            = slot_of(stk_rd_r);
            tbl_wr_data.valid      = 1'b1;
            tbl_wr_data.fold       = 1'b0;
            tbl_wr_data.end_ln     = line_r;
            res.pair_found         = 1'b1;
            res.pair_start         = stk_rd_r;
            res.pair_end           = line_r;
            res.is_block_start     = 1'b1;
            res.next_line          = {1'b0, stk_rd_r} + NEXT_W'(1);
          end
        end
      end
      OP_TOGGLE, OP_VIEW: begin
        if (tbl_rd.valid) begin
          if (op_r == OP_TOGGLE) begin
            tbl_wr_en        = 1'b1;
            tbl_wr_data.fold = rep_fold;
          end
          res.pair_start     = line_r;
          res.pair_end       = tbl_rd.end_ln;
          res.is_block_start = 1'b1;
          res.folded         = rep_fold;
          res.next_line      = rep_fold ? ({1'b0, tbl_rd.end_ln} + NEXT_W'(1))
                                        : ({1'b0, line_r} + NEXT_W'(1));
        end else if (op_r == OP_TOGGLE) begin
          res.status = ST_NOT_BLOCK;
        end else begin
          res.next_line = {1'b0, line_r} + NEXT_W'(1);
        end
      end
      default: begin
        res = '0;
      end
    endcase
    tbl_wr_en = tbl_wr_en && exec_go;
  end

  // Stack memory: push in execute, read top at accept
  always_ff @(posedge clk) begin
    if (exec_go && push_en) begin
      stk_mem[count_r[STK_AW-1:0]] <= line_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (count_r != '0)) begin
      stk_rd_r <= stk_mem[cnt_dec[STK_AW-1:0]];
    end
  end

  // Stack count
  always_comb begin
    count_nxt = count_r;
    if (exec_go && push_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (exec_go && pop_en) begin
      count_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register: load on execute, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_pair_found     = out_res_r.pair_found;
  assign out_pair_start     = out_res_r.pair_start;
  assign out_pair_end       = out_res_r.pair_end;
  assign out_is_block_start = out_res_r.is_block_start;
  assign out_folded         = out_res_r.folded;
  assign out_next_line      = out_res_r.next_line;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !in_ready)
    else $error("word accepted during table clear");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == FSM_EXEC))
    else $error("accepted word not executed next cycle");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && res.pair_found) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("matched close did not pop the stack");

  a_exec_loads: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("executed word produced no result");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for brace_block_fold_table
// Drives scanned characters, fold toggles and line views through the
// valid/ready input channel, tracks the brace stack and block table in a
// scoreboard and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module testbench
  import bbft_pkg::*;
();

  // Operation code that the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Brace stack and block table tracking, with the queue of pending results
  class fold_scoreboard;
    logic [LINE_W-1:0] open_lines[STACK_DEPTH_DEF];
    int unsigned depth;
    logic [LINE_W-1:0] end_of[MAX_LINES_DEF];
    bit has_block[MAX_LINES_DEF];
    bit fold_on[MAX_LINES_DEF];
    res_t pending_results[$];
    logic [LINE_W-1:0] recent_starts[$];
    int unsigned errors;

    function new();
      depth = 0;
      errors = 0;
      foreach (has_block[i]) begin
        has_block[i] = 1'b0;
        fold_on[i] = 1'b0;
      end
    endfunction

    // Block status of one line as the display loop sees it
    function res_t line_view(logic [LINE_W-1:0] ln);
      res_t r;
      r = '0;
      r.status = ST_OK;
      if (has_block[ln]) begin
        r.pair_start = ln;
        r.pair_end = end_of[ln];
        r.is_block_start = 1'b1;
        r.folded = fold_on[ln];
        r.next_line = fold_on[ln] ? {1'b0, end_of[ln]} + 1'b1 : {1'b0, ln} + 1'b1;
      end else begin
        r.next_line = {1'b0, ln} + 1'b1;
      end
      return r;
    endfunction

    // Update the tracked state for one accepted word and queue its result
    function void note_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [LINE_W-1:0] ln);
      res_t r;
      logic [LINE_W-1:0] start;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_SCAN: begin
          if (ch == CH_OPEN) begin
            if (depth >= STACK_DEPTH_DEF) begin
              r.status = ST_OVERFLOW;
            end else begin
              open_lines[depth] = ln;
              depth++;
            end
          end else if (ch == CH_CLOSE) begin
            if (depth == 0) begin
              r.status = ST_UNMATCHED;
            end else begin
              depth--;
              start = open_lines[depth];
              end_of[start] = ln;
              has_block[start] = 1'b1;
              fold_on[start] = 1'b0;
              r.pair_found = 1'b1;
              r.pair_start = start;
              r.pair_end = ln;
              r.is_block_start = 1'b1;
              r.next_line = {1'b0, start} + 1'b1;
              recent_starts.push_back(start);
              if (recent_starts.size() > 32) void'(recent_starts.pop_front());
            end
          end
        end
        OP_TOGGLE: begin
          if (has_block[ln]) begin
            fold_on[ln] = ~fold_on[ln];
            r = line_view(ln);
          end else begin
            r.status = ST_NOT_BLOCK;
          end
        end
        OP_VIEW: r = line_view(ln);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // Check one accepted result word against the oldest pending one
    function void match_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none pending, expected none actual %h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("pair_found", want.pair_found, got.pair_found);
      compare_field("pair_start", want.pair_start, got.pair_start);
      compare_field("pair_end", want.pair_end, got.pair_end);
      compare_field("is_block_start", want.is_block_start, got.is_block_start);
      compare_field("folded", want.folded, got.folded);
      compare_field("next_line", want.next_line, got.next_line);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [LINE_W-1:0] in_line = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic out_pair_found;
  logic [LINE_W-1:0] out_pair_start;
  logic [LINE_W-1:0] out_pair_end;
  logic out_is_block_start;
  logic out_folded;
  logic [NEXT_W-1:0] out_next_line;

  fold_scoreboard tracker = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned cycles = 0;
  logic [LINE_W-1:0] cur_line = '0;

  brace_block_fold_table u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_char_code       (in_char_code),
    .in_line            (in_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_pair_found     (out_pair_found),
    .out_pair_start     (out_pair_start),
    .out_pair_end       (out_pair_end),
    .out_is_block_start (out_is_block_start),
    .out_folded         (out_folded),
    .out_next_line      (out_next_line)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("brace_block_fold_table: mismatch");
      $finish;
    end
  end

  // Take result words and stall the receiver at random
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.pair_found = out_pair_found;
      got.pair_start = out_pair_start;
      got.pair_end = out_pair_end;
      got.is_block_start = out_is_block_start;
      got.folded = out_folded;
      got.next_line = out_next_line;
      tracker.match_result(got);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Present one input word, idling first at random, and hold it until taken
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [LINE_W-1:0] ln);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_char_code <= ch;
    in_line <= ln;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(op, ch, ln);
  endtask

  // Hold the input idle until every pending result has come back
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  // Nest open braces past the stack depth
  task automatic overflow_burst();
    int unsigned k;
    for (k = 0; k < STACK_DEPTH_DEF + 2; k++) begin
      send_word(OP_SCAN, CH_OPEN, cur_line);
      if ($urandom_range(0, 3) == 0) cur_line = cur_line + 1'b1;
    end
  endtask

  // Toggle and view targets: mostly recorded block starts, sometimes any line
  function automatic logic [LINE_W-1:0] pick_target();
    int unsigned idx;
    if (tracker.recent_starts.size() != 0 && $urandom_range(0, 99) < 80) begin
      idx = $urandom_range(0, tracker.recent_starts.size() - 1);
      return tracker.recent_starts[idx];
    end
    return LINE_W'($urandom_range(0, 1023));
  endfunction

  // Mostly balanced brace text with folds and views mixed in, plus noise
  task automatic run_random(input int unsigned count, input bit force_burst);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    if (force_burst) begin
      overflow_burst();
      sent = STACK_DEPTH_DEF + 2;
    end
    while (sent < count) begin
      pick = $urandom_range(0, 999);
      if (pick < 4) begin
        overflow_burst();
        sent += STACK_DEPTH_DEF + 2;
      end else begin
        pick = pick / 10;
        if (pick < 25 || (pick < 50 && tracker.depth == 0 && pick >= 28)) begin
          send_word(OP_SCAN, CH_OPEN, cur_line);
        end else if (pick < 50) begin
          send_word(OP_SCAN, CH_CLOSE, cur_line);
        end else if (pick < 65) begin
          send_word(OP_SCAN, CHAR_W'($urandom_range(0, 255)), cur_line);
        end else if (pick < 80) begin
          send_word(OP_TOGGLE, CHAR_W'($urandom_range(0, 255)), pick_target());
        end else if (pick < 95) begin
          send_word(OP_VIEW, CHAR_W'($urandom_range(0, 255)), pick_target());
        end else begin
          send_word(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                    LINE_W'($urandom_range(0, 1023)));
        end
        sent++;
      end
      // advance the text position; a rare jump lets blocks end before they start
      pick = $urandom_range(0, 99);
      if (pick < 2) cur_line = LINE_W'($urandom_range(0, 1023));
      else if (pick < 35) cur_line = cur_line + LINE_W'($urandom_range(1, 3));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unmatched close, pairs, folds, next line past line 1023
    send_word(OP_VIEW, 8'h00, 10'd0);
    send_word(OP_VIEW, 8'hFF, 10'd1023);
    send_word(OP_TOGGLE, 8'h00, 10'd5);
    send_word(OP_SCAN, CH_CLOSE, 10'd3);
    send_word(OP_SCAN, 8'h00, 10'd1);
    send_word(OP_SCAN, 8'hFF, 10'd1023);
    send_word(OP_SCAN, CH_OPEN, 10'd0);
    send_word(OP_SCAN, CH_OPEN, 10'd10);
    send_word(OP_SCAN, 8'h41, 10'd15);
    send_word(OP_SCAN, CH_CLOSE, 10'd20);
    send_word(OP_SCAN, CH_CLOSE, 10'd1023);
    send_word(OP_TOGGLE, 8'h00, 10'd10);
    send_word(OP_VIEW, 8'h00, 10'd10);
    send_word(OP_TOGGLE, 8'hFF, 10'd0);
    send_word(OP_VIEW, 8'h00, 10'd0);
    // block whose end line precedes its start line
    send_word(OP_SCAN, CH_OPEN, 10'd900);
    send_word(OP_SCAN, CH_CLOSE, 10'd5);
    send_word(OP_TOGGLE, 8'h00, 10'd900);
    // closing a folded start again clears its fold
    send_word(OP_SCAN, CH_OPEN, 10'd10);
    send_word(OP_SCAN, CH_CLOSE, 10'd30);
    send_word(OP_TOGGLE, 8'h00, 10'd10);
    send_word(OP_TOGGLE, 8'h00, 10'd10);
    send_word(OP_UNUSED, 8'hFF, 10'd1023);
    send_word(OP_UNUSED, 8'h00, 10'd0);
    drain_pause();

    // random phases: slow receiver, then slow sender, then full rate
    send_idle = 11;
    recv_idle = 60;
    run_random(700, 1'b1);
    drain_pause();
    send_idle = 60;
    recv_idle = 11;
    run_random(700, 1'b0);
    drain_pause();
    send_idle = 0;
    recv_idle = 0;
    run_random(700, 1'b0);
    drain_pause();
    repeat (8) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("brace_block_fold_table: match");
    end else begin
      $display("brace_block_fold_table: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bbft_pkg.sv
hw/rtl/bbft_table.sv
hw/rtl/brace_block_fold_table.sv
tb/testbench.sv
